// ===== hdl/lif_pkg.sv =====
// ----------------------------------------------------------------------------
// lif_pkg
// Shared types, constants and helpers of the LIF neuron update pipeline.
// ----------------------------------------------------------------------------
package lif_pkg;

    localparam int NEURONS          = 1024;
    localparam int IDX_W            = $clog2(NEURONS);
    localparam int REFR_W           = 10;
    localparam int REFRACTORY_STEPS = 20;
    localparam int DECAY_W          = 17;
    localparam int PROD_W           = 48;
    localparam int SUM_W            = 50;

    localparam logic [DECAY_W:0] ONE_Q = 18'd65536;

    localparam logic [7:0] REG_MEMBRANE_DECAY = 8'd0;
    localparam logic [7:0] REG_EXCIT_GAIN     = 8'd1;
    localparam logic [7:0] REG_INHIB_GAIN     = 8'd2;
    localparam logic [7:0] REG_DRIVE_GAIN     = 8'd3;
    localparam logic [7:0] REG_EXCIT_DECAY    = 8'd4;
    localparam logic [7:0] REG_INHIB_DECAY    = 8'd5;
    localparam logic [7:0] REG_FIRE_THRESHOLD = 8'd6;
    localparam logic [7:0] REG_RESET_LEVEL    = 8'd7;

    typedef struct packed {
        logic [31:0]       count;
        logic [REFR_W-1:0] refr;
        logic [31:0]       inhib;
        logic [31:0]       excit;
        logic [31:0]       membrane;
    } t_mem_word;

    function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic [31:0] r;
        if (v > $signed({{(SUM_W-31){1'b0}}, {31{1'b1}}})) begin
            r = 32'h7FFF_FFFF;
        end else if (v < $signed({{(SUM_W-31){1'b1}}, {31{1'b0}}})) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/lif_ram.sv =====
// ----------------------------------------------------------------------------
// lif_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lif_neuron_exp_synapse_update_top.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_exp_synapse_update_top
// LIF neuron with exponential synaptic currents, one neuron step per beat.
// Pipeline: RAM read, multiply, sum, fire/write back, from input beat to result
// beat. Throughput: one beat per cycle while the output does not stall; a beat
// for a neuron still in the pipeline waits until its write back, as do output stalls.
// Reset: synchronous; a clearing pass zeroes all 1024 words of the state RAM,
// no input beat is taken meanwhile; config writes are always taken.
// ----------------------------------------------------------------------------
module lif_neuron_exp_synapse_update_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // neuron_index[9:0], excit_spikes, inhib_spikes, drive_current,
    // ramp_current (32 each), zero pad to 144
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // spike_neuron[9:0], fired[10], zero pad to 16
    output logic [15:0]  o_m_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int IW = lif_pkg::IDX_W;
    localparam int PW = lif_pkg::PROD_W;
    localparam int SW = lif_pkg::SUM_W;

    // configuration
    logic [16:0] r_md, r_ed, r_id;
    logic [31:0] r_eg, r_ig, r_dg, r_thr, r_rst_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md      <= 17'd65536;
            r_ed      <= 17'd65536;
            r_id      <= 17'd65536;
            r_eg      <= '0;
            r_ig      <= '0;
            r_dg      <= '0;
            r_thr     <= 32'd983040;
            r_rst_lvl <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lif_pkg::REG_MEMBRANE_DECAY: r_md      <= i_cfg_data[16:0];
                lif_pkg::REG_EXCIT_GAIN:     r_eg      <= i_cfg_data;
                lif_pkg::REG_INHIB_GAIN:     r_ig      <= i_cfg_data;
                lif_pkg::REG_DRIVE_GAIN:     r_dg      <= i_cfg_data;
                lif_pkg::REG_EXCIT_DECAY:    r_ed      <= i_cfg_data[16:0];
                lif_pkg::REG_INHIB_DECAY:    r_id      <= i_cfg_data[16:0];
                lif_pkg::REG_FIRE_THRESHOLD: r_thr     <= i_cfg_data;
                lif_pkg::REG_RESET_LEVEL:    r_rst_lvl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline control
    logic          r_clearing;
    logic [IW-1:0] r_clr_addr;
    logic          en, hazard, in_acc;
    logic          r_v1, r_v2, r_v3, r_ov;
    logic [IW-1:0] r_idx1, r_idx2, r_idx3, r_oidx;
    logic          r_ofired;

    logic [IW-1:0] in_idx;
    assign in_idx = i_s_tdata[IW-1:0];

    assign en     = !r_ov || i_m_tready;
    assign hazard = (r_v1 && r_idx1 == in_idx) || (r_v2 && r_idx2 == in_idx)
                 || (r_v3 && r_idx3 == in_idx);
    assign o_s_tready = en && !r_clearing && !hazard;
    assign in_acc     = i_s_tvalid && o_s_tready;

    // state RAM
    lif_pkg::t_mem_word q, wword;
    logic               we;
    logic [IW-1:0]      waddr;

    lif_ram #(
        .WIDTH($bits(lif_pkg::t_mem_word)),
        .DEPTH(lif_pkg::NEURONS)
    ) u_state (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wword),
        .i_re   (in_acc),
        .i_raddr(in_idx),
        .o_rdata(q)
    );

    // stage 1: inputs alongside RAM read
    logic signed [31:0] r_ex1, r_in1, r_dr1, r_ra1;

    // stage 2: products
    logic signed [63:0] p_v, p_e, p_i, p_d, p_ee, p_er, p_ii;
    logic signed [17:0] ed_c;
    logic signed [PW-1:0] r_pv, r_pe, r_pi, r_pd, r_pee, r_per, r_pii;
    logic signed [31:0]   r_ex2, r_in2;
    lif_pkg::t_mem_word   r_w2;

    assign ed_c = $signed(lif_pkg::ONE_Q - {1'b0, r_ed});
    assign p_v  = $signed(q.membrane) * $signed({1'b0, r_md});
    assign p_e  = $signed(q.excit) * $signed(r_eg);
    assign p_i  = $signed(q.inhib) * $signed(r_ig);
    assign p_d  = r_dr1 * $signed(r_dg);
    assign p_ee = $signed(q.excit) * $signed({1'b0, r_ed});
    assign p_er = r_ra1 * ed_c;
    assign p_ii = $signed(q.inhib) * $signed({1'b0, r_id});

    // stage 3: sums and saturation
    logic signed [SW-1:0] s_v, s_e, s_i;
    logic [31:0]          r_vn3, r_ie3, r_ii3, r_cnt3;
    logic [lif_pkg::REFR_W-1:0] r_refr3;

    assign s_v = SW'(r_pv) + SW'(r_pe) + SW'(r_pi) + SW'(r_pd);
    assign s_e = SW'(r_pee) + SW'(r_per) + SW'(r_ex2);
    assign s_i = SW'(r_pii) + SW'(r_in2);

    // stage 4: fire decision and write back
    logic fire;
    assign fire = $signed(r_vn3) >= $signed(r_thr);

    always_comb begin
        wword          = '0;
        waddr          = r_clr_addr;
        we             = r_clearing;
        if (!r_clearing) begin
            waddr          = r_idx3;
            we             = en && r_v3;
            wword.membrane = fire ? r_rst_lvl : r_vn3;
            wword.excit    = r_ie3;
            wword.inhib    = r_ii3;
            wword.refr     = fire ? lif_pkg::REFR_W'(lif_pkg::REFRACTORY_STEPS) : r_refr3;
            wword.count    = (fire && r_cnt3 != 32'hFFFF_FFFF) ? r_cnt3 + 32'd1 : r_cnt3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(lif_pkg::NEURONS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (en) begin
                r_v1 <= in_acc;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_idx1 <= in_idx;
            r_ex1  <= i_s_tdata[41:10];
            r_in1  <= i_s_tdata[73:42];
            r_dr1  <= i_s_tdata[105:74];
            r_ra1  <= i_s_tdata[137:106];

            r_pv   <= p_v[63:16];
            r_pe   <= p_e[63:16];
            r_pi   <= p_i[63:16];
            r_pd   <= p_d[63:16];
            r_pee  <= p_ee[63:16];
            r_per  <= p_er[63:16];
            r_pii  <= p_ii[63:16];
            r_ex2  <= r_ex1;
            r_in2  <= r_in1;
            r_w2   <= q;
            r_idx2 <= r_idx1;

            r_vn3   <= (r_w2.refr == '0) ? lif_pkg::sat32(s_v) : r_w2.membrane;
            r_refr3 <= (r_w2.refr == '0) ? r_w2.refr : r_w2.refr - 1'b1;
            r_ie3   <= lif_pkg::sat32(s_e);
            r_ii3   <= lif_pkg::sat32(s_i);
            r_cnt3  <= r_w2.count;
            r_idx3  <= r_idx2;

            r_oidx   <= r_idx3;
            r_ofired <= fire;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {5'd0, r_ofired, r_oidx};

    // assertions
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !o_s_tready)
        else $error("input taken during clearing pass");

    a_no_flight_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !(r_v1 || r_v2 || r_v3 || r_ov))
        else $error("item in flight during clearing pass");

    a_stage_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v3) |=> r_ov)
        else $error("result lost at output stage");

    a_no_dup_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2) |-> (r_idx1 != r_idx2))
        else $error("same neuron twice in flight");

endmodule

// ===== bench/lif_spike_checker.sv =====
// ----------------------------------------------------------------------------
// lif_spike_checker
// Watches the input, result and register channels of the LIF neuron update
// block, keeps its own copy of the neuron memories and registers, predicts
// the fired flag of every input beat and compares it with each result beat.
// ----------------------------------------------------------------------------
module lif_spike_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [15:0]  i_m_tdata,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);

    typedef struct {
        logic [9:0] neuron;
        logic       fired;
    } t_spike;

    t_spike spikes_due[$];

    longint membrane_decay, excit_gain, inhib_gain, drive_gain;
    longint excit_decay, inhib_decay, fire_threshold, reset_level;

    logic signed [31:0]         v_mem   [lif_pkg::NEURONS];
    logic signed [31:0]         ex_cur  [lif_pkg::NEURONS];
    logic signed [31:0]         in_cur  [lif_pkg::NEURONS];
    logic [lif_pkg::REFR_W-1:0] refr    [lif_pkg::NEURONS];
    logic [31:0]                count   [lif_pkg::NEURONS];

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic advance_neuron(logic [143:0] d);
        logic [9:0] idx;
        longint ex_sp, in_sp, drv, ramp, v, ie, ii;
        logic    hit;
        idx   = d[9:0];
        ex_sp = longint'($signed(d[41:10]));
        in_sp = longint'($signed(d[73:42]));
        drv   = longint'($signed(d[105:74]));
        ramp  = longint'($signed(d[137:106]));
        v  = longint'(v_mem[idx]);
        ie = longint'(ex_cur[idx]);
        ii = longint'(in_cur[idx]);
        if (refr[idx] == 0) begin
            v = clip32(qmul(v, membrane_decay) + qmul(ie, excit_gain)
                       + qmul(ii, inhib_gain) + qmul(drv, drive_gain));
        end else begin
            refr[idx] = refr[idx] - 1'b1;
        end
        ie = clip32(qmul(ie, excit_decay) + qmul(ramp, 65536 - excit_decay) + ex_sp);
        ii = clip32(qmul(ii, inhib_decay) + in_sp);
        hit = (v >= fire_threshold);
        if (hit) begin
            if (count[idx] != 32'hFFFF_FFFF) count[idx] = count[idx] + 1;
            refr[idx] = lif_pkg::REFR_W'(lif_pkg::REFRACTORY_STEPS);
            v = reset_level;
        end
        v_mem[idx]  = v[31:0];
        ex_cur[idx] = ie[31:0];
        in_cur[idx] = ii[31:0];
        return hit;
    endfunction

    assign o_pending = spikes_due.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_spike e;
        if (!i_rst_n) begin
            membrane_decay = 65536;
            excit_gain     = 0;
            inhib_gain     = 0;
            drive_gain     = 0;
            excit_decay    = 65536;
            inhib_decay    = 65536;
            fire_threshold = 983040;
            reset_level    = 0;
            for (int i = 0; i < lif_pkg::NEURONS; i++) begin
                v_mem[i] = 0; ex_cur[i] = 0; in_cur[i] = 0; refr[i] = 0; count[i] = 0;
            end
            spikes_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lif_pkg::REG_MEMBRANE_DECAY:
                        membrane_decay = longint'(i_cfg_data[16:0]);
                    lif_pkg::REG_EXCIT_GAIN:
                        excit_gain     = longint'($signed(i_cfg_data));
                    lif_pkg::REG_INHIB_GAIN:
                        inhib_gain     = longint'($signed(i_cfg_data));
                    lif_pkg::REG_DRIVE_GAIN:
                        drive_gain     = longint'($signed(i_cfg_data));
                    lif_pkg::REG_EXCIT_DECAY:
                        excit_decay    = longint'(i_cfg_data[16:0]);
                    lif_pkg::REG_INHIB_DECAY:
                        inhib_decay    = longint'(i_cfg_data[16:0]);
                    lif_pkg::REG_FIRE_THRESHOLD:
                        fire_threshold = longint'($signed(i_cfg_data));
                    lif_pkg::REG_RESET_LEVEL:
                        reset_level    = longint'($signed(i_cfg_data));
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                e.neuron = i_s_tdata[9:0];
                e.fired  = advance_neuron(i_s_tdata);
                spikes_due.push_back(e);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (spikes_due.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result beat: neuron %0d fired %0b",
                                 i_m_tdata[9:0], i_m_tdata[10]);
                    o_errors <= o_errors + 1;
                end else begin
                    e = spikes_due.pop_front();
                    if (i_m_tdata[9:0] !== e.neuron || i_m_tdata[10] !== e.fired
                        || i_m_tdata[15:11] !== 5'd0) begin
                        if (o_errors < 10)
                            $display("mismatch: neuron exp %0d act %0d, fired exp %0b act %0b",
                                     e.neuron, i_m_tdata[9:0], e.fired, i_m_tdata[10]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/lif_neuron_exp_synapse_update_top_tb.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_exp_synapse_update_top_tb
// Drives neuron step beats and register writes into the LIF update block
// under several register settings and idling mixes; the checker predicts and
// compares every result beat, this module gives the verdict.
// ----------------------------------------------------------------------------
module lif_neuron_exp_synapse_update_top_tb;

    localparam int LIMIT = 300000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [143:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [15:0]  o_m_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    int errors;
    int pending;
    int cycles;
    int s_idle;
    int m_idle;
    logic hold_req;
    logic hold_on;

    lif_neuron_exp_synapse_update_top DUT (.*);

    lif_spike_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[lif_neuron_exp_synapse_update_top] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= !hold_on && ($urandom_range(99) >= m_idle);
    end

    initial begin
        hold_on = 1'b0;
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_on <= 1'b1;
            repeat (300) @(posedge i_clk);
            hold_on <= 1'b0;
            hold_req = 1'b0;
        end
    end

    function automatic logic [31:0] rand_q(int kind);
        case (kind)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 20 << 16)) - (32'd6 << 16);
        endcase
    endfunction

    function automatic logic [143:0] step_beat(logic [9:0] idx, logic [31:0] ex,
                                               logic [31:0] inh, logic [31:0] drv,
                                               logic [31:0] ramp);
        return {6'd0, ramp, drv, inh, ex, idx};
    endfunction

    function automatic logic [143:0] random_beat();
        logic [9:0] idx;
        idx = ($urandom_range(3) == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(7));
        return step_beat(idx, rand_q($urandom_range(9)), rand_q($urandom_range(9)),
                         rand_q($urandom_range(9)), rand_q($urandom_range(9)));
    endfunction

    task automatic send_step(logic [143:0] d);
        while ($urandom_range(99) < s_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] vals[8]);
        drain();
        for (int i = 0; i < 10; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (i < 8) ? 8'(i) : ((i == 8) ? 8'd8 : 8'd255);
            i_cfg_data  <= (i < 8) ? vals[i] : $urandom;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_run(int n, int si, int mi);
        s_idle = si;
        m_idle = mi;
        for (int i = 0; i < n; i++) send_step(random_beat());
    endtask

    initial begin
        logic [31:0] regs[8];
        cycles      = 0;
        hold_req    = 1'b0;
        s_idle      = 9;
        m_idle      = 58;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats, reset register values
        send_step(step_beat(10'd0, 32'd0, 32'd0, 32'd0, 32'd0));
        send_step(step_beat(10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_step(step_beat(10'd1023, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000));
        for (int i = 0; i < 6; i++)
            send_step(step_beat(10'd5, 32'h0004_0000, 32'hFFFE_0000,
                                32'h0010_0000, 32'h0001_0000));

        regs = '{32'h0000_E000, 32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000,
                 32'h0000_C000, 32'h0000_8000, 32'h000F_0000, 32'h0000_0000};
        write_regs(regs);
        // drive high enough to fire, then refractory steps on the same neuron
        for (int i = 0; i < 12; i++)
            send_step(step_beat(10'd3, 32'h0002_0000, 32'h0001_0000,
                                32'h0008_0000, 32'hFFFF_0000));

        hold_req = 1'b1;
        random_run(170, 9, 58);
        drain();

        regs = '{32'h0001_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0000_0000, 32'h0001_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        write_regs(regs);
        random_run(80, 58, 9);

        regs = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
                 32'h0001_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        write_regs(regs);
        random_run(80, 58, 9);

        regs = '{32'h0000_F000, 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000,
                 32'h0001_2000, 32'h0000_E000, 32'h0003_0000, 32'hFFFE_0000};
        write_regs(regs);
        random_run(170, 0, 0);

        drain();
        if (errors == 0) begin
            $display("[lif_neuron_exp_synapse_update_top] OK");
        end else begin
            $display("[lif_neuron_exp_synapse_update_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/lif_pkg.sv
hdl/lif_ram.sv
hdl/lif_neuron_exp_synapse_update_top.sv
bench/lif_spike_checker.sv
bench/lif_neuron_exp_synapse_update_top_tb.sv
